>>> hdl/bmf_pkg.sv
// Shared constants, types and codes of the 21x21 box mean filter.
package bmf_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int RADIUS     = 10;
    localparam int DIAM       = 2 * RADIUS + 1;
    localparam int STORE_ROWS = 2 * RADIUS;
    localparam int AREA       = DIAM * DIAM;

    localparam int SIZE_W = 13;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int SLOT_W = $clog2(STORE_ROWS);
    localparam int RAD_W  = $clog2(RADIUS);
    localparam int LS_DEPTH = STORE_ROWS * MAX_WIDTH;
    localparam int LS_AW  = $clog2(LS_DEPTH);
    localparam int CS_W   = $clog2(DIAM * 255 + 1);
    localparam int WS_W   = $clog2(AREA * 255 + 1);

    // floor(x / AREA) = (x * DIV_MULT) >> DIV_SHIFT for every window sum
    localparam int DIV_SHIFT = 26;
    localparam int DIV_MULT  = (1 << DIV_SHIFT) / AREA + 1;
    localparam int MULT_W    = $clog2(DIV_MULT + 1);

    localparam int CMDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 8;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // op kinds
    localparam logic OP_PIX = 1'b0;
    localparam logic OP_RD  = 1'b1;

    typedef logic [SIZE_W-1:0] t_size;

    typedef struct packed {
        logic              kind;
        logic [7:0]        pix;
        logic [SLOT_W-1:0] wr_slot;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] rd_slot;
        logic [COL_W-1:0]  rd_col;
        logic              first_row;
        logic              have_old;
        logic              col0;
        logic              col_lt_diam;
        logic              emit;
        logic              interior;
        logic              last;
        logic              eof;
    } t_op;

    typedef struct packed {
        logic [7:0] value;
        logic       eof;
        logic       last;
    } t_res;

endpackage

>>> hdl/bmf_front.sv
// Front end: accepts beats, tracks frame position and issues ops.
module bmf_front import bmf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  logic [7:0] i_pixel,
    input  logic  i_drain,
    input  t_size i_cfg_w,
    input  t_size i_cfg_h,
    output logic  o_op_push,
    output t_op   o_op,
    input  logic  i_op_full
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FRAME = 2'd1;
    localparam logic [1:0] PH_DRAIN = 2'd2;

    function automatic t_size clamp_size(input t_size v, input t_size hi);
        if (v < t_size'(DIAM)) return t_size'(DIAM);
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [SLOT_W-1:0] back_slot(input logic [SLOT_W-1:0] s,
                                                    input int unsigned k);
        if (s >= SLOT_W'(k)) return s - SLOT_W'(k);
        return s + SLOT_W'(STORE_ROWS - k);
    endfunction

    logic [1:0]        r_phase, n_phase;
    t_size             r_fw, n_fw, r_fh, n_fh;
    logic [COL_W-1:0]  r_row, n_row, r_col, n_col;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_burst, n_burst;
    logic [RAD_W-1:0]  r_bk, n_bk;
    logic [SLOT_W-1:0] r_bslot, n_bslot;
    logic [COL_W-1:0]  r_bcol, n_bcol;
    logic [COL_W-1:0]  r_dcol, n_dcol;
    logic [RAD_W-1:0]  r_drow, n_drow;
    logic [SLOT_W-1:0] r_dslot, n_dslot;

    logic accept;
    assign o_full = i_op_full | r_burst;
    assign accept = i_push & ~o_full;

    always_comb begin
        logic              new_frame;
        t_size             cur_w, cur_h;
        logic [COL_W-1:0]  cur_r, cur_c;
        logic [SLOT_W-1:0] cur_slot, orow_slot;
        logic              eol, last_row, burst, d_eol;
        n_phase = r_phase; n_fw = r_fw; n_fh = r_fh;
        n_row = r_row; n_col = r_col; n_slot = r_slot;
        n_burst = r_burst; n_bk = r_bk; n_bslot = r_bslot; n_bcol = r_bcol;
        n_dcol = r_dcol; n_drow = r_drow; n_dslot = r_dslot;
        o_op = '0;
        o_op_push = 1'b0;

        new_frame = (r_phase != PH_FRAME);
        cur_w    = new_frame ? clamp_size(i_cfg_w, t_size'(MAX_WIDTH)) : r_fw;
        cur_h    = new_frame ? clamp_size(i_cfg_h, t_size'(MAX_HEIGHT)) : r_fh;
        cur_r    = new_frame ? '0 : r_row;
        cur_c    = new_frame ? '0 : r_col;
        cur_slot = new_frame ? '0 : r_slot;
        orow_slot = back_slot(cur_slot, RADIUS);
        eol      = ({1'b0, cur_c} + 1'b1) == cur_w;
        last_row = ({1'b0, cur_r} + 1'b1) >= cur_h;
        burst    = eol && (cur_r >= COL_W'(RADIUS));
        d_eol    = ({1'b0, r_dcol} + 1'b1) == r_fw;

        if (r_burst) begin
            if (!i_op_full) begin
                o_op_push      = 1'b1;
                o_op.kind      = OP_RD;
                o_op.rd_slot   = r_bslot;
                o_op.rd_col    = r_bcol;
                o_op.emit      = 1'b1;
                o_op.last      = (r_bk == RAD_W'(RADIUS - 1));
                n_bcol         = r_bcol + 1'b1;
                n_bk           = r_bk + 1'b1;
                if (r_bk == RAD_W'(RADIUS - 1)) begin
                    n_burst = 1'b0;
                end
            end
        end else if (accept) begin
            if (!i_drain) begin
                o_op_push        = 1'b1;
                o_op.kind        = OP_PIX;
                o_op.pix         = i_pixel;
                o_op.wr_slot     = cur_slot;
                o_op.col         = cur_c;
                o_op.rd_slot     = orow_slot;
                o_op.rd_col      = cur_c - COL_W'(RADIUS);
                o_op.first_row   = (cur_r == '0);
                o_op.have_old    = (cur_r >= COL_W'(STORE_ROWS));
                o_op.col0        = (cur_c == '0);
                o_op.col_lt_diam = (cur_c < COL_W'(DIAM));
                o_op.emit        = (cur_r >= COL_W'(RADIUS)) && (cur_c >= COL_W'(RADIUS));
                o_op.interior    = (cur_r >= COL_W'(STORE_ROWS)) &&
                                   (cur_c >= COL_W'(STORE_ROWS));
                o_op.last        = ~burst;
                n_phase = PH_FRAME;
                n_fw    = cur_w;
                n_fh    = cur_h;
                if (burst) begin
                    n_burst = 1'b1;
                    n_bk    = '0;
                    n_bslot = orow_slot;
                    n_bcol  = COL_W'(cur_w - t_size'(RADIUS));
                end
                if (eol) begin
                    n_col = '0;
                    if (last_row) begin
                        n_row   = '0;
                        n_slot  = '0;
                        n_phase = PH_DRAIN;
                        n_dcol  = '0;
                        n_drow  = '0;
                        n_dslot = back_slot(cur_slot, RADIUS - 1);
                    end else begin
                        n_row  = cur_r + 1'b1;
                        n_slot = (cur_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : cur_slot + 1'b1;
                    end
                end else begin
                    n_row  = cur_r;
                    n_slot = cur_slot;
                    n_col  = cur_c + 1'b1;
                end
            end else if (r_phase == PH_DRAIN) begin
                o_op_push    = 1'b1;
                o_op.kind    = OP_RD;
                o_op.rd_slot = r_dslot;
                o_op.rd_col  = r_dcol;
                o_op.emit    = 1'b1;
                o_op.last    = 1'b1;
                o_op.eof     = d_eol && (r_drow == RAD_W'(RADIUS - 1));
                if (o_op.eof) begin
                    n_phase = PH_IDLE;
                end else if (d_eol) begin
                    n_dcol  = '0;
                    n_drow  = r_drow + 1'b1;
                    n_dslot = (r_dslot == SLOT_W'(STORE_ROWS - 1)) ? '0 : r_dslot + 1'b1;
                end else begin
                    n_dcol = r_dcol + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_fw    <= t_size'(3136);
            r_fh    <= t_size'(2199);
            r_row   <= '0;
            r_col   <= '0;
            r_slot  <= '0;
            r_burst <= 1'b0;
            r_bk    <= '0;
            r_dcol  <= '0;
            r_drow  <= '0;
            r_dslot <= '0;
        end else begin
            r_phase <= n_phase;
            r_fw    <= n_fw;
            r_fh    <= n_fh;
            r_row   <= n_row;
            r_col   <= n_col;
            r_slot  <= n_slot;
            r_burst <= n_burst;
            r_bk    <= n_bk;
            r_dcol  <= n_dcol;
            r_drow  <= n_drow;
            r_dslot <= n_dslot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bslot <= n_bslot;
        r_bcol  <= n_bcol;
    end

endmodule

>>> hdl/bmf_cmdq.sv
// Short op queue between front end and back end.
module bmf_cmdq import bmf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_op
);

    localparam int PW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_op            r_mem [0:CMDQ_DEPTH-1];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_op;
    end

endmodule

>>> hdl/bmf_back.sv
// Back end: line store, column sums, window sum, divide and result queue.
module bmf_back import bmf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_op_valid,
    input  t_op        i_op,
    output logic       o_op_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_value,
    output logic       o_end_of_frame,
    output logic       o_last
);

    localparam int OPW = $clog2(OUTQ_DEPTH);
    localparam int OCW = $clog2(OUTQ_DEPTH + 1);

    logic [7:0]      m_ls [0:LS_DEPTH-1];
    logic [CS_W-1:0] m_cs [0:MAX_WIDTH-1];

    logic            r_v1, r_v2, r_v3;
    t_op             r_op1, r_op2, r_op3;
    logic [7:0]      r_lsa, r_lsb, r_pv2, r_pv3;
    logic [CS_W-1:0] r_cs;
    logic [WS_W-1:0] r_ws, n_ws;
    logic [CS_W-1:0] r_tap [0:DIAM-1];
    logic [WS_W+MULT_W-1:0] r_prod;

    t_res            r_oq [0:OUTQ_DEPTH-1];
    logic [OPW-1:0]  r_wp, r_rp;
    logic [OCW-1:0]  r_cnt;

    logic [OCW:0]    used;
    logic [CS_W-1:0] col_sum, old_px, cs_wd;
    logic            pix_wr, oq_push;
    logic [LS_AW-1:0] addr_a, addr_b, addr_w;
    t_res            res3;

    // credit: never issue more than the result queue can still absorb
    assign used     = (OCW+1)'(r_cnt) + (OCW+1)'(r_v1) + (OCW+1)'(r_v2) + (OCW+1)'(r_v3);
    assign o_op_pop = i_op_valid && (used < (OCW+1)'(OUTQ_DEPTH));

    assign addr_a = {i_op.wr_slot, i_op.col};
    assign addr_b = {i_op.rd_slot, i_op.rd_col};
    assign addr_w = {r_op1.wr_slot, r_op1.col};

    assign pix_wr  = r_v1 && (r_op1.kind == OP_PIX);
    assign col_sum = (r_op1.first_row ? '0 : r_cs) + CS_W'(r_op1.pix);
    assign old_px  = r_op1.have_old ? CS_W'(r_lsa) : '0;
    assign cs_wd   = col_sum - old_px;

    always_comb begin
        if (r_op1.col0) begin
            n_ws = WS_W'(col_sum);
        end else if (r_op1.col_lt_diam) begin
            n_ws = r_ws + WS_W'(col_sum);
        end else begin
            n_ws = r_ws + WS_W'(col_sum) - WS_W'(r_tap[DIAM-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_lsa <= m_ls[addr_a];
        r_lsb <= m_ls[addr_b];
        r_cs  <= m_cs[i_op.col];
        if (pix_wr) begin
            m_ls[addr_w]     <= r_op1.pix;
            m_cs[r_op1.col]  <= cs_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_wr) begin
            r_ws     <= n_ws;
            r_tap[0] <= col_sum;
            for (int i = 1; i < DIAM; i++) r_tap[i] <= r_tap[i-1];
        end
        r_op1  <= i_op;
        r_op2  <= r_op1;
        r_pv2  <= r_lsb;
        r_op3  <= r_op2;
        r_pv3  <= r_pv2;
        r_prod <= r_ws * MULT_W'(DIV_MULT);
    end

    assign res3.value = r_op3.interior ? r_prod[DIV_SHIFT +: 8] : r_pv3;
    assign res3.eof   = r_op3.eof;
    assign res3.last  = r_op3.last;
    assign oq_push    = r_v3 && r_op3.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_v1 <= o_op_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (oq_push) r_wp <= r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + OCW'(oq_push) - OCW'(i_pop && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) r_oq[r_wp] <= res3;
    end

    assign o_empty        = (r_cnt == '0);
    assign o_value        = r_oq[r_rp].value;
    assign o_end_of_frame = r_oq[r_rp].eof;
    assign o_last         = r_oq[r_rp].last;

endmodule

>>> hdl/box_mean_filter_21x21.sv
// Top level of the streaming 21x21 box mean filter.
// Usage:
//  - Input queue side: push/full. One beat = one 8-bit gray pixel in raster
//    order (i_drain low) or one drain beat (i_drain high) after the frame.
//  - Result queue side: empty/pop. Each beat carries o_value, o_end_of_frame
//    (final pixel of the output frame) and o_last (last result of its input).
//  - Interior pixels get floor(window sum / 441); pixels within 10 of an edge
//    pass through. Output trails input by 10 rows and 10 columns; at each row
//    end the 10 right-border pixels follow; 10 rows of drain beats finish.
//  - Throughput: one pixel per clock while full is low. A row end that
//    produces output adds one line-store read per right-border pixel,
//    during which full is high. Each drain beat issues one line-store read.
//  - Path: a result passes the op queue, memory read, window sum and divide
//    stages before it enters the result queue.
//  - Receiver stall: results collect in an 8-deep queue; the back end issues
//    only with free room, so the op queue and then full back up.
//  - Reset (synchronous, active low) empties both queues, restarts position
//    tracking and sets width 3136, height 2199. Frame sizes are taken at the
//    first pixel of a frame and clamped to 21..4096.
//  - Config: APB, width at 0x0, height at 0x4, no wait states.
module box_mean_filter_21x21 import bmf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_pixel,
    input  logic        i_drain,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_value,
    output logic        o_end_of_frame,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_size r_cfg_w, r_cfg_h;
    logic  cfg_wr;

    logic  op_push, op_full, op_valid, op_pop;
    t_op   op_in, op_head;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    // registers decode on word index only
    assign prdata = (paddr[2] == REG_HEIGHT) ? {{(32-SIZE_W){1'b0}}, r_cfg_h}
                                             : {{(32-SIZE_W){1'b0}}, r_cfg_w};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= t_size'(3136);
            r_cfg_h <= t_size'(2199);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) r_cfg_w <= pwdata[SIZE_W-1:0];
            else                       r_cfg_h <= pwdata[SIZE_W-1:0];
        end
    end

    bmf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_pixel   (i_pixel),
        .i_drain   (i_drain),
        .i_cfg_w   (r_cfg_w),
        .i_cfg_h   (r_cfg_h),
        .o_op_push (op_push),
        .o_op      (op_in),
        .i_op_full (op_full)
    );

    bmf_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_op    (op_in),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_valid (op_valid),
        .o_op    (op_head)
    );

    bmf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op_valid     (op_valid),
        .i_op           (op_head),
        .o_op_pop       (op_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_value        (o_value),
        .o_end_of_frame (o_end_of_frame),
        .o_last         (o_last)
    );

endmodule

>>> hdl/bmf_checker.sv
// Port-level checks of the box mean filter, bound to the top level.
module bmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic        o_end_of_frame,
    input logic        o_last,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // nothing waits right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // frame end closes the beats of its input
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_end_of_frame) |-> o_last)
        else $error("end_of_frame without last");

    // a waiting result stays until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped without pop");

    // written register reads back
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=>
        (paddr[2] != $past(paddr[2]) || prdata[12:0] == $past(pwdata[12:0])))
        else $error("register readback mismatch");

endmodule

bind box_mean_filter_21x21 bmf_checker u_bmf_checker (.*);

>>> bench/testbench.sv
// Self-checking testbench for the 21x21 box mean filter: directed tests with random pixels.
`timescale 1ns / 100ps

module testbench;
    import bmf_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE      = 24;    // quiet time after the last expected result
    localparam logic [2:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};

    typedef enum {PH_IDLE, PH_FRAME, PH_DRAIN} t_filt_phase;

    typedef struct {
        logic [7:0] value;
        logic       eof;
        logic       last;
    } t_filt_result;

    // DUT pins; the inputs are known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_pixel = '0;
    logic        i_drain = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_value;
    logic        o_end_of_frame;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    box_mean_filter_21x21 u_top (.*);

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Filter shadow: own copy of line store, column sums and counters
    // ---------------------------------------------------------------
    byte unsigned   line_mem [0:LS_DEPTH-1];
    int unsigned    col_sums [0:MAX_WIDTH-1];
    int unsigned    recent_sums [0:DIAM-1];
    int unsigned    win_sum, row_pos, col_pos, drained;
    int unsigned    cfg_w = 3136, cfg_h = 2199;
    int unsigned    frame_w, frame_h;
    t_filt_phase    phase = PH_IDLE;

    t_filt_result   expected_pixels [$];
    int             n_errors = 0;
    int unsigned    cycles = 0;

    // stimulus shaping knobs, changed per test
    int             gap_pct   = 25;   // chance of a gap after a push beat
    int             stall_pct = 20;   // chance of a pop stall

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < DIAM) return DIAM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned stored_pixel(int unsigned r, int unsigned c);
        return line_mem[(r % STORE_ROWS) * MAX_WIDTH + (c % MAX_WIDTH)];
    endfunction

    // Works out the results of one accepted beat and queues them.
    task automatic predict_filter(input logic [7:0] pix, input logic drn);
        t_filt_result res [$];
        t_filt_result one;
        int unsigned  r, c, idx, oldest, prev, s, slot, orow;
        res = {};
        one.last = 1'b0;
        if (drn) begin
            if (phase != PH_DRAIN) return;     // drain outside draining: ignored
            orow = frame_h - RADIUS + drained / frame_w;
            one.value = 8'(stored_pixel(orow, drained % frame_w));
            drained++;
            one.eof = (drained >= RADIUS * frame_w);
            if (one.eof) phase = PH_IDLE;
            one.last = 1'b1;
            expected_pixels.push_back(one);
            return;
        end
        // a pixel outside a frame (also mid-drain) opens a new frame
        if (phase != PH_FRAME) begin
            frame_w = clamp_size(cfg_w, MAX_WIDTH);
            frame_h = clamp_size(cfg_h, MAX_HEIGHT);
            row_pos = 0;
            col_pos = 0;
            phase   = PH_FRAME;
        end
        r = row_pos;
        c = col_pos;
        idx    = (r % STORE_ROWS) * MAX_WIDTH + c;
        oldest = (r >= STORE_ROWS) ? line_mem[idx] : 0;
        prev   = (r == 0) ? 0 : col_sums[c];
        s      = prev + pix;
        slot   = c % DIAM;
        col_sums[c] = (s - oldest) & 32'hFFFF;
        line_mem[idx] = pix;
        if (c == 0) win_sum = s;
        else if (c < DIAM) win_sum += s;
        else win_sum = win_sum + s - recent_sums[slot];
        recent_sums[slot] = s & 32'hFFFF;

        one.eof = 1'b0;
        if (r >= RADIUS) begin
            orow = r - RADIUS;
            if (c >= RADIUS) begin
                // interior only once a full window exists; borders pass through
                if (r >= STORE_ROWS && c >= STORE_ROWS) one.value = 8'(win_sum / AREA);
                else one.value = 8'(stored_pixel(orow, c - RADIUS));
                res.push_back(one);
            end
            if (c + 1 == frame_w)
                for (int k = 0; k < RADIUS; k++) begin
                    one.value = 8'(stored_pixel(orow, frame_w - RADIUS + k));
                    res.push_back(one);
                end
        end

        if (c + 1 >= frame_w) begin
            col_pos = 0;
            if (r + 1 >= frame_h) begin
                row_pos = 0;
                drained = 0;
                phase   = PH_DRAIN;
            end else begin
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
        end

        if (res.size() > 0) res[res.size()-1].last = 1'b1;
        foreach (res[i]) expected_pixels.push_back(res[i]);
    endtask

    // ---------------------------------------------------------------
    // Result side: random pop stalls and the checker
    // ---------------------------------------------------------------
    int pop_hold = 0;

    always @(posedge i_clk) begin
        if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            // mostly short stalls, now and then a long one
            pop_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 3);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_filt_result exp_beat;
        if (i_rst_n && pop && !empty) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result beat: value %0d", o_value);
                n_errors++;
            end else begin
                exp_beat = expected_pixels.pop_front();
                if (o_value !== exp_beat.value) begin
                    $error("value: expected %0d, got %0d", exp_beat.value, o_value);
                    n_errors++;
                end
                if (o_end_of_frame !== exp_beat.eof) begin
                    $error("end_of_frame: expected %0b, got %0b",
                           exp_beat.eof, o_end_of_frame);
                    n_errors++;
                end
                if (o_last !== exp_beat.last) begin
                    $error("last: expected %0b, got %0b", exp_beat.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    // Sends one beat; push stays high into the next beat unless a gap is drawn.
    task automatic push_beat(input logic [7:0] pix, input logic drn);
        push    <= 1'b1;
        i_pixel <= pix;
        i_drain <= drn;
        do @(posedge i_clk); while (full);
        predict_filter(pix, drn);
        if ($urandom_range(0, 99) < gap_pct) begin
            push <= 1'b0;
            repeat (($urandom_range(0, 15) == 0) ? $urandom_range(8, 30)
                                                 : $urandom_range(1, 3))
                @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // fill < 0: random content, else a flat frame of that gray level
    task automatic send_frame(input int unsigned w, input int unsigned h, input int fill);
        for (int unsigned i = 0; i < w * h; i++)
            push_beat((fill < 0) ? rand_pixel() : fill[7:0], 1'b0);
    endtask

    task automatic send_drain(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            push_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Everything delivered and the pipeline quiet; push left low.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_WIDTH) cfg_w = data & 32'h1FFF;
        else cfg_h = data & 32'h1FFF;
    endtask

    task automatic set_size(input logic [31:0] w, input logic [31:0] h);
        wait_idle();
        cfg_write(ADDR_WIDTH, w);
        cfg_write(ADDR_HEIGHT, h);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // drain beats with no frame behind them cause nothing
    task automatic test_idle_drain();
        send_drain(4);
    endtask

    // upper write bits dropped, height below the minimum clamps to 21; the
    // window slides at column 21, borders and interior come out, then a
    // back-to-back drain ends the frame and stray drains after it are ignored
    task automatic test_frame_and_drain();
        set_size(32'd22 | 32'hFFFF_E000, 32'd20);
        gap_pct = 25;
        stall_pct = 20;
        send_frame(clamp_size(cfg_w, MAX_WIDTH), clamp_size(cfg_h, MAX_HEIGHT), -1);
        gap_pct = 0;                // back-to-back stretch
        stall_pct = 0;
        send_drain(RADIUS * frame_w);
        gap_pct = 25;
        stall_pct = 20;
        send_drain(2);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_drain();
        test_frame_and_drain();

        wait_idle();
        if (n_errors == 0 && expected_pixels.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/bmf_pkg.sv
hdl/bmf_front.sv
hdl/bmf_cmdq.sv
hdl/bmf_back.sv
hdl/box_mean_filter_21x21.sv
hdl/bmf_checker.sv
bench/testbench.sv
